### hw/rtl/fris_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fris_pkg: shared types and constants of the four-register interpreter step
// Holds the beat payload structs, the decoded-instruction format passed from
// the front end to the back end, and the state and code enums.
// ---------------------------------------------------------------------------
package fris_pkg;

    localparam int DATA_W            = 32;
    localparam int LINE_W            = 8;
    localparam int TARGET_W          = 7;
    localparam int KIND_W            = 4;
    localparam int GPR_IDX_W         = 2;
    localparam int QUEUE_DEPTH       = 2;
    localparam int DIV_STEPS         = 32;
    localparam int PROGRAM_LINES_DEF = 128;
    localparam int APB_ADDR_W        = 3;
    localparam int APB_DATA_W        = 32;
    localparam int REG_IDX_W         = APB_ADDR_W - 2;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_LINE_COUNT = 1'b0;

    // Instruction kind codes as they arrive on the input channel.
    localparam logic [KIND_W-1:0] KIND_READ  = 4'd0;
    localparam logic [KIND_W-1:0] KIND_PRINT = 4'd1;
    localparam logic [KIND_W-1:0] KIND_MOV   = 4'd2;
    localparam logic [KIND_W-1:0] KIND_ADD   = 4'd3;
    localparam logic [KIND_W-1:0] KIND_SUB   = 4'd4;
    localparam logic [KIND_W-1:0] KIND_MUL   = 4'd5;
    localparam logic [KIND_W-1:0] KIND_DIV   = 4'd6;
    localparam logic [KIND_W-1:0] KIND_JMP   = 4'd7;
    localparam logic [KIND_W-1:0] KIND_JE    = 4'd8;
    localparam logic [KIND_W-1:0] KIND_JNE   = 4'd9;
    localparam logic [KIND_W-1:0] KIND_JG    = 4'd10;
    localparam logic [KIND_W-1:0] KIND_JGE   = 4'd11;
    localparam logic [KIND_W-1:0] KIND_JL    = 4'd12;
    localparam logic [KIND_W-1:0] KIND_JLE   = 4'd13;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_READ,
        OP_PRINT,
        OP_MOV,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_JMP,
        OP_JCC
    } op_t;

    typedef enum logic [2:0] {
        COND_EQ,
        COND_NE,
        COND_GT,
        COND_GE,
        COND_LT,
        COND_LE
    } cond_t;

    typedef enum logic {
        BK_EXEC,
        BK_DIV
    } bk_state_t;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic                 src_is_reg;
        logic [GPR_IDX_W-1:0] src_reg;
        logic [DATA_W-1:0]    src_imm;
        logic [GPR_IDX_W-1:0] dst_reg;
        logic                 cmp_is_reg;
        logic [GPR_IDX_W-1:0] cmp_reg;
        logic [DATA_W-1:0]    cmp_imm;
        logic [TARGET_W-1:0]  jump_target;
        logic [DATA_W-1:0]    read_value;
    } in_item_t;

    typedef struct packed {
        logic [LINE_W-1:0] next_line;
        logic              jump_taken;
        logic              print_valid;
        logic [DATA_W-1:0] print_value;
        logic              divide_fault;
        logic              done_res;
    } out_item_t;

    typedef struct packed {
        op_t                  op;
        cond_t                cond;
        logic                 src_is_reg;
        logic [GPR_IDX_W-1:0] src_reg;
        logic [DATA_W-1:0]    src_imm;
        logic [GPR_IDX_W-1:0] dst_reg;
        logic                 cmp_is_reg;
        logic [GPR_IDX_W-1:0] cmp_reg;
        logic [DATA_W-1:0]    cmp_imm;
        logic [TARGET_W-1:0]  jump_target;
        logic [DATA_W-1:0]    read_value;
    } dec_item_t;

endpackage
`default_nettype wire

### hw/rtl/fris_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fris_front: instruction intake and decode
// Accepts input beats while the queue has room and turns the raw kind code
// into an operation class and a compare condition.
// ---------------------------------------------------------------------------
module fris_front
    import fris_pkg::*;
(
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_data,
    input  wire logic      q_full,
    output logic           q_push,
    output dec_item_t      q_item
);

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_item.src_is_reg  = in_data.src_is_reg;
        q_item.src_reg     = in_data.src_reg;
        q_item.src_imm     = in_data.src_imm;
        q_item.dst_reg     = in_data.dst_reg;
        q_item.cmp_is_reg  = in_data.cmp_is_reg;
        q_item.cmp_reg     = in_data.cmp_reg;
        q_item.cmp_imm     = in_data.cmp_imm;
        q_item.jump_target = in_data.jump_target;
        q_item.read_value  = in_data.read_value;
        q_item.op          = OP_NOP;
        q_item.cond        = COND_EQ;
        unique case (in_data.kind)
            KIND_READ:  q_item.op = OP_READ;
            KIND_PRINT: q_item.op = OP_PRINT;
            KIND_MOV:   q_item.op = OP_MOV;
            KIND_ADD:   q_item.op = OP_ADD;
            KIND_SUB:   q_item.op = OP_SUB;
            KIND_MUL:   q_item.op = OP_MUL;
            KIND_DIV:   q_item.op = OP_DIV;
            KIND_JMP:   q_item.op = OP_JMP;
            KIND_JE:
            begin
                q_item.op   = OP_JCC;
                q_item.cond = COND_EQ;
            end
            KIND_JNE:
            begin
                q_item.op   = OP_JCC;
                q_item.cond = COND_NE;
            end
            KIND_JG:
            begin
                q_item.op   = OP_JCC;
                q_item.cond = COND_GT;
            end
            KIND_JGE:
            begin
                q_item.op   = OP_JCC;
                q_item.cond = COND_GE;
            end
            KIND_JL:
            begin
                q_item.op   = OP_JCC;
                q_item.cond = COND_LT;
            end
            KIND_JLE:
            begin
                q_item.op   = OP_JCC;
                q_item.cond = COND_LE;
            end
            // Unused kind codes only advance the line.
            default:    q_item.op = OP_NOP;
        endcase
    end

endmodule
`default_nettype wire

### hw/rtl/fris_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fris_queue: decoded-instruction queue
// A short first-in first-out buffer between decode and execution.
// ---------------------------------------------------------------------------
module fris_queue
    import fris_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire dec_item_t push_item,
    output logic           full,
    output logic           head_valid,
    output dec_item_t      head_item,
    input  wire logic      pop
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    dec_item_t         slot_mem [QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [CW-1:0]     count_reg;
    logic [PW-1:0]     wr_ptr_next;
    logic [PW-1:0]     rd_ptr_next;
    logic [CW-1:0]     count_next;

    assign full       = (count_reg == CW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/fris_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fris_div: iterative signed divider
// Radix-2 restoring division on magnitudes, one quotient bit per cycle,
// quotient truncated toward zero. The result holds until the next start.
// ---------------------------------------------------------------------------
module fris_div
    import fris_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DATA_W-1:0] num,
    input  wire logic [DATA_W-1:0] den,
    output logic                   done,
    output logic [DATA_W-1:0]      quo
);

    localparam int SW = $clog2(DIV_STEPS + 1);

    logic [SW-1:0]     count_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              neg_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] dm_reg;
    logic [DATA_W:0]   rem_shift;
    logic [DATA_W:0]   diff;

    assign rem_shift = {rem_reg, quo_reg[DATA_W-1]};
    assign diff      = rem_shift - {1'b0, dm_reg};
    assign done      = done_reg;
    assign quo       = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            count_reg <= SW'(DIV_STEPS);
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg - SW'(1);
            if (count_reg == SW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[DATA_W-1] ^ den[DATA_W-1];
            rem_reg <= '0;
            quo_reg <= num[DATA_W-1] ? (DATA_W'(0) - num) : num;
            dm_reg  <= den[DATA_W-1] ? (DATA_W'(0) - den) : den;
        end
        else if (busy_reg)
        begin
            if (!diff[DATA_W])
            begin
                rem_reg <= diff[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b0};
            end
        end
    end

endmodule
`default_nettype wire

### hw/rtl/fris_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fris_back: execution back end
// Holds the four general registers and the line counter, executes the queue
// head, runs divisions through the iterative divider and drives the result
// register.
// ---------------------------------------------------------------------------
module fris_back
    import fris_pkg::*;
#(
    parameter int PROGRAM_LINES = PROGRAM_LINES_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [LINE_W-1:0] line_count,
    input  wire logic              q_valid,
    input  wire dec_item_t         q_item,
    output logic                   q_pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output out_item_t              out_data
);

    localparam int LIM_W = $clog2(PROGRAM_LINES + 1);
    localparam int CW    = (LIM_W > LINE_W) ? LIM_W : LINE_W;
    localparam logic [CW-1:0] LIMIT_MAX = CW'(PROGRAM_LINES);

    bk_state_t             state_reg;
    bk_state_t             state_next;
    logic [DATA_W-1:0]     ax_reg;
    logic [DATA_W-1:0]     bx_reg;
    logic [DATA_W-1:0]     cx_reg;
    logic [DATA_W-1:0]     dx_reg;
    logic [LINE_W-1:0]     line_reg;
    logic                  out_valid_reg;
    out_item_t             out_data_reg;

    logic [DATA_W-1:0]     src_val;
    logic [DATA_W-1:0]     cmp_val;
    logic [DATA_W-1:0]     dst_val;
    logic [DATA_W-1:0]     mul_lo;
    logic                  slot_free;
    logic                  complete;
    logic                  wr_en;
    logic [DATA_W-1:0]     wr_val;
    logic                  taken;
    logic                  cond_hit;
    out_item_t             res;
    logic                  div_start;
    logic                  div_done;
    logic [DATA_W-1:0]     div_quo;

    function automatic logic [DATA_W-1:0] gpr_pick(
        input logic [GPR_IDX_W-1:0] idx,
        input logic [DATA_W-1:0]    r0,
        input logic [DATA_W-1:0]    r1,
        input logic [DATA_W-1:0]    r2,
        input logic [DATA_W-1:0]    r3
    );
        logic [DATA_W-1:0] val;
        unique case (idx)
            2'd0:    val = r0;
            2'd1:    val = r1;
            2'd2:    val = r2;
            default: val = r3;
        endcase
        return val;
    endfunction

    assign src_val = q_item.src_is_reg
                   ? gpr_pick(q_item.src_reg, ax_reg, bx_reg, cx_reg, dx_reg)
                   : q_item.src_imm;
    assign cmp_val = q_item.cmp_is_reg
                   ? gpr_pick(q_item.cmp_reg, ax_reg, bx_reg, cx_reg, dx_reg)
                   : q_item.cmp_imm;
    assign dst_val = gpr_pick(q_item.dst_reg, ax_reg, bx_reg, cx_reg, dx_reg);
    assign mul_lo  = dst_val * src_val;

    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    fris_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (src_val),
        .den   (dst_val),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        unique case (q_item.cond)
            COND_EQ: cond_hit = (src_val == cmp_val);
            COND_NE: cond_hit = (src_val != cmp_val);
            COND_GT: cond_hit = ($signed(src_val) >  $signed(cmp_val));
            COND_GE: cond_hit = ($signed(src_val) >= $signed(cmp_val));
            COND_LT: cond_hit = ($signed(src_val) <  $signed(cmp_val));
            COND_LE: cond_hit = ($signed(src_val) <= $signed(cmp_val));
            default: cond_hit = 1'b0;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_EXEC:
            begin
                if (div_start)
                begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (complete)
                begin
                    state_next = BK_EXEC;
                end
            end
        endcase
    end

    // Outputs and datapath control.
    always_comb
    begin
        div_start = 1'b0;
        complete  = 1'b0;
        wr_en     = 1'b0;
        wr_val    = src_val;
        taken     = 1'b0;
        res       = '0;
        unique case (state_reg)
            BK_EXEC:
            begin
                div_start = q_valid && (q_item.op == OP_DIV) && (dst_val != '0);
                complete  = q_valid && slot_free && !div_start;
            end
            BK_DIV:
            begin
                complete = div_done && slot_free;
            end
        endcase

        unique case (q_item.op)
            OP_READ:
            begin
                wr_en  = 1'b1;
                wr_val = q_item.read_value;
            end
            OP_PRINT:
            begin
                res.print_valid = 1'b1;
                res.print_value = src_val;
            end
            OP_MOV:
            begin
                wr_en  = 1'b1;
                wr_val = src_val;
            end
            OP_ADD:
            begin
                wr_en  = 1'b1;
                wr_val = dst_val + src_val;
            end
            OP_SUB:
            begin
                wr_en  = 1'b1;
                wr_val = dst_val - src_val;
            end
            OP_MUL:
            begin
                wr_en  = 1'b1;
                wr_val = mul_lo;
            end
            OP_DIV:
            begin
                // Completing in the execute state means the divisor was zero.
                wr_en            = (state_reg == BK_DIV);
                wr_val           = div_quo;
                res.divide_fault = (state_reg == BK_EXEC);
            end
            OP_JMP:  taken = 1'b1;
            OP_JCC:  taken = cond_hit;
            default: taken = 1'b0;
        endcase

        res.jump_taken = taken;
        res.next_line  = taken ? LINE_W'(q_item.jump_target) : (line_reg + LINE_W'(1));
        res.done_res   = (res.next_line >= line_count) || (CW'(res.next_line) >= LIMIT_MAX);
    end

    assign q_pop = complete;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_EXEC;
            ax_reg        <= '0;
            bx_reg        <= '0;
            cx_reg        <= '0;
            dx_reg        <= '0;
            line_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (complete)
            begin
                line_reg      <= res.next_line;
                out_valid_reg <= 1'b1;
                if (wr_en)
                begin
                    unique case (q_item.dst_reg)
                        2'd0:    ax_reg <= wr_val;
                        2'd1:    bx_reg <= wr_val;
                        2'd2:    cx_reg <= wr_val;
                        default: dx_reg <= wr_val;
                    endcase
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (complete)
        begin
            out_data_reg <= res;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/four_register_interpreter_step_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// four_register_interpreter_step_top: four-register interpreter step
// Executes one decoded instruction per input beat on four signed 32-bit
// registers and a line counter and returns one result beat per instruction.
// ---------------------------------------------------------------------------
//
//   Channel   Signals                              Direction  Beat
//   --------  -----------------------------------  ---------  ----------------
//   input     in_valid / in_ready / in_data        in         one instruction
//   output    out_valid / out_ready / out_data     out        one result
//   config    psel penable pwrite paddr pwdata     in         line_count write
//             prdata pready                        out
//
// A non-divide instruction passes the queue slot and the output register,
// and the back end retires one such instruction per cycle while the output
// register is free. A divide with a nonzero divisor holds the back end to
// start, run the radix-2 divider loop and retire; that loop sets the worst rate.
// Reset clears the registers, the line counter, line_count and the queue.
// The input stalls only when the decode queue is full; the back end stalls
// only while a finished result waits in the output register.
//
// The front end decodes each input beat into a short queue; the back end
// executes from the queue head so that each side stalls independently.
module four_register_interpreter_step_top
    import fris_pkg::*;
#(
    parameter int PROGRAM_LINES = PROGRAM_LINES_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire in_item_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output out_item_t                  out_data,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    logic [LINE_W-1:0]    line_count_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;
    logic                 q_push;
    logic                 q_full;
    dec_item_t            q_in_item;
    logic                 q_valid;
    dec_item_t            q_head;
    logic                 q_pop;

    // Configuration port: registers sit at word-aligned byte addresses.
    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign prdata  = (reg_idx == REG_LINE_COUNT) ? APB_DATA_W'(line_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg <= '0;
        end
        else if (cfg_wr && (reg_idx == REG_LINE_COUNT))
        begin
            line_count_reg <= pwdata[LINE_W-1:0];
        end
    end

    fris_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_in_item)
    );

    fris_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_in_item),
        .full       (q_full),
        .head_valid (q_valid),
        .head_item  (q_head),
        .pop        (q_pop)
    );

    fris_back #(
        .PROGRAM_LINES (PROGRAM_LINES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_count (line_count_reg),
        .q_valid    (q_valid),
        .q_item     (q_head),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    // The back end retires only an instruction that is really in the queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("queue popped while empty");

    // Retiring must never overwrite a result that has not been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (!out_valid || out_ready))
        else $error("result register overwritten");

    // A print neither jumps nor faults.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.print_valid && (out_data.jump_taken || out_data.divide_fault)))
        else $error("print result carries jump or fault");

    // A taken jump lands inside the seven-bit target range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.jump_taken) |-> (out_data.next_line[LINE_W-1] == 1'b0))
        else $error("jump target out of range");

endmodule
`default_nettype wire

### verif/instr_result_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// instr_result_checker: result scoreboard of the four-register interpreter step
// Keeps its own copy of the four registers, the line counter and line_count,
// works out one result for every accepted instruction beat, and compares the
// result beats against those predictions in order.
// ---------------------------------------------------------------------------
module instr_result_checker
    import fris_pkg::*;
#(
    parameter int PROGRAM_LINES = PROGRAM_LINES_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_ready,
    input  wire in_item_t              in_data,
    input  wire logic                  out_valid,
    input  wire logic                  out_ready,
    input  wire out_item_t             out_data,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic                  pready,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output int                         mismatch_count,
    output int                         results_owed
);

    logic [DATA_W-1:0] gpr_copy [4];
    logic [LINE_W-1:0] line_copy;
    logic [LINE_W-1:0] line_count_copy;
    out_item_t         owed_results [$];
    out_item_t         predicted;
    out_item_t         oldest;

    // Signed quotient truncated toward zero, done on magnitudes so that the
    // most negative value divided by minus one simply wraps.
    function automatic logic [DATA_W-1:0] div_toward_zero(input logic [DATA_W-1:0] num,
                                                          input logic [DATA_W-1:0] den);
        logic [DATA_W-1:0] num_mag;
        logic [DATA_W-1:0] den_mag;
        logic [DATA_W-1:0] quot;
        num_mag = num[DATA_W-1] ? -num : num;
        den_mag = den[DATA_W-1] ? -den : den;
        quot    = num_mag / den_mag;
        return (num[DATA_W-1] ^ den[DATA_W-1]) ? -quot : quot;
    endfunction

    task automatic execute_instr(input in_item_t ins, output out_item_t res);
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] rhs;
        logic [DATA_W-1:0] dst_val;
        logic [LINE_W-1:0] nxt;
        logic              taken;
        int unsigned       lines_eff;
        lhs     = ins.src_is_reg ? gpr_copy[ins.src_reg] : ins.src_imm;
        rhs     = ins.cmp_is_reg ? gpr_copy[ins.cmp_reg] : ins.cmp_imm;
        dst_val = gpr_copy[ins.dst_reg];
        res     = '0;
        taken   = 1'b0;
        case (ins.kind)
            KIND_READ:  gpr_copy[ins.dst_reg] = ins.read_value;
            KIND_PRINT:
            begin
                res.print_valid = 1'b1;
                res.print_value = lhs;
            end
            KIND_MOV:   gpr_copy[ins.dst_reg] = lhs;
            KIND_ADD:   gpr_copy[ins.dst_reg] = dst_val + lhs;
            KIND_SUB:   gpr_copy[ins.dst_reg] = dst_val - lhs;
            KIND_MUL:   gpr_copy[ins.dst_reg] = dst_val * lhs;
            KIND_DIV:
            begin
                // The destination is the divisor; a zero divisor leaves it alone.
                if (dst_val == '0)
                    res.divide_fault = 1'b1;
                else
                    gpr_copy[ins.dst_reg] = div_toward_zero(lhs, dst_val);
            end
            KIND_JMP:   taken = 1'b1;
            KIND_JE:    taken = (lhs == rhs);
            KIND_JNE:   taken = (lhs != rhs);
            KIND_JG:    taken = ($signed(lhs) > $signed(rhs));
            KIND_JGE:   taken = ($signed(lhs) >= $signed(rhs));
            KIND_JL:    taken = ($signed(lhs) < $signed(rhs));
            KIND_JLE:   taken = ($signed(lhs) <= $signed(rhs));
            default:    ;
        endcase
        nxt       = taken ? LINE_W'(ins.jump_target) : line_copy + 1'b1;
        line_copy = nxt;
        lines_eff = (line_count_copy > PROGRAM_LINES) ? PROGRAM_LINES : line_count_copy;
        res.next_line  = nxt;
        res.jump_taken = taken;
        res.done_res   = (nxt >= lines_eff);
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] exp_val,
                               input logic [DATA_W-1:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                gpr_copy[i] = '0;
            line_copy       = '0;
            line_count_copy = '0;
            owed_results.delete();
            results_owed    = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready
                && paddr[APB_ADDR_W-1:2] == REG_LINE_COUNT)
                line_count_copy = pwdata[LINE_W-1:0];
            // Predict before comparing so that a beat entering and one leaving on
            // the same edge are handled in order.
            if (in_valid && in_ready)
            begin
                execute_instr(in_data, predicted);
                owed_results.push_back(predicted);
            end
            if (out_valid && out_ready)
            begin
                if (owed_results.size() == 0)
                begin
                    $error("result beat with no instruction outstanding");
                    mismatch_count++;
                end
                else
                begin
                    oldest = owed_results.pop_front();
                    check_field("next_line", oldest.next_line, out_data.next_line);
                    check_field("jump_taken", oldest.jump_taken, out_data.jump_taken);
                    check_field("print_valid", oldest.print_valid, out_data.print_valid);
                    check_field("print_value", oldest.print_value, out_data.print_value);
                    check_field("divide_fault", oldest.divide_fault, out_data.divide_fault);
                    check_field("done_res", oldest.done_res, out_data.done_res);
                end
            end
            results_owed = owed_results.size();
        end
    end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: testbench of the four-register interpreter step
// Drives instruction beats and line_count writes into the block, throttles
// both channels, and leaves all prediction and comparison to the result
// checker instantiated beside it. Prints the verdict at the end of the run.
// ---------------------------------------------------------------------------
module tb;
    import fris_pkg::*;

    // Register names used by the directed instructions.
    localparam logic [GPR_IDX_W-1:0] GPR_AX = 2'd0;
    localparam logic [GPR_IDX_W-1:0] GPR_BX = 2'd1;
    localparam logic [GPR_IDX_W-1:0] GPR_CX = 2'd2;
    localparam logic [GPR_IDX_W-1:0] GPR_DX = 2'd3;

    // Operand source selector.
    localparam logic OPND_IMM = 1'b0;
    localparam logic OPND_REG = 1'b1;

    // The two kind codes that have no operation behind them.
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 4'd14;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 4'd15;

    localparam logic [DATA_W-1:0] INT_MIN_W = 32'h8000_0000;
    localparam logic [DATA_W-1:0] INT_MAX_W = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] MINUS_ONE = 32'hFFFF_FFFF;

    // Cycles allowed after the last result for anything stray to show up;
    // a divide keeps the back end busy for its whole divider loop.
    localparam int SETTLE_CYCLES = 40;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_item_t             out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int mismatch_count;
    int results_owed;

    // Percent chance, per cycle, that the sender or the receiver sits idle.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    // When nonzero, the receiver holds out_ready low for this many cycles.
    int hold_left     = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    four_register_interpreter_step_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    instr_result_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .mismatch_count(mismatch_count),
        .results_owed  (results_owed)
    );

    // Builds one instruction beat from its fields, in the order of the struct.
    function automatic in_item_t encode_instr(
        input logic [KIND_W-1:0]    kind,
        input logic                 src_is_reg,
        input logic [GPR_IDX_W-1:0] src_reg,
        input logic [DATA_W-1:0]    src_imm,
        input logic [GPR_IDX_W-1:0] dst_reg,
        input logic                 cmp_is_reg,
        input logic [GPR_IDX_W-1:0] cmp_reg,
        input logic [DATA_W-1:0]    cmp_imm,
        input logic [TARGET_W-1:0]  jump_target,
        input logic [DATA_W-1:0]    read_value);
        in_item_t ins;
        ins.kind        = kind;
        ins.src_is_reg  = src_is_reg;
        ins.src_reg     = src_reg;
        ins.src_imm     = src_imm;
        ins.dst_reg     = dst_reg;
        ins.cmp_is_reg  = cmp_is_reg;
        ins.cmp_reg     = cmp_reg;
        ins.cmp_imm     = cmp_imm;
        ins.jump_target = jump_target;
        ins.read_value  = read_value;
        return ins;
    endfunction

    // Data words lean toward the values where wrapping, signed comparison and
    // division behave differently; small values keep quotients interesting.
    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 32'd1;
            2:       return MINUS_ONE;
            3:       return INT_MIN_W;
            4:       return INT_MAX_W;
            5:       return DATA_W'($urandom_range(0, 20)) - 32'd10;
            default: return $urandom();
        endcase
    endfunction

    // A random instruction. In a straight run every jump is turned into a mov,
    // so the line counter only counts up and eventually wraps past its top.
    function automatic in_item_t rand_instr(input bit straight);
        in_item_t ins;
        ins.kind = KIND_W'($urandom_range(0, 15));
        if (straight && ins.kind >= KIND_JMP && ins.kind <= KIND_JLE)
            ins.kind = KIND_MOV;
        ins.src_is_reg = 1'($urandom_range(0, 1));
        ins.src_reg    = GPR_IDX_W'($urandom_range(0, 3));
        ins.src_imm    = rand_word();
        ins.dst_reg    = GPR_IDX_W'($urandom_range(0, 3));
        // One compare in four sees the same operand on both sides.
        if ($urandom_range(0, 3) == 0)
        begin
            ins.cmp_is_reg = ins.src_is_reg;
            ins.cmp_reg    = ins.src_reg;
            ins.cmp_imm    = ins.src_imm;
        end
        else
        begin
            ins.cmp_is_reg = 1'($urandom_range(0, 1));
            ins.cmp_reg    = GPR_IDX_W'($urandom_range(0, 3));
            ins.cmp_imm    = rand_word();
        end
        ins.jump_target = TARGET_W'($urandom());
        ins.read_value  = rand_word();
        return ins;
    endfunction

    // Offers one instruction beat and returns right after the edge that
    // accepts it. A gap, if any, comes first so valid never drops once up.
    task automatic send_instr(input in_item_t ins);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= ins;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Returns once every predicted result has come out. The count sampled at
    // an edge can only lag behind by results still leaving, so it is safe.
    task automatic wait_drained();
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
    endtask

    // Setup cycle then access cycle; pready is checked even though the block
    // keeps it high.
    task automatic write_line_count(input logic [LINE_W-1:0] lines);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_LINE_COUNT, 2'b00};
        pwdata  <= APB_DATA_W'(lines);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_random(input int count, input bit straight);
        for (int i = 0; i < count; i++)
            send_instr(rand_instr(straight));
    endtask

    // Lowers valid, lets everything drain, then writes a new line count while
    // the block is idle.
    task automatic reconfigure(input logic [LINE_W-1:0] lines);
        in_valid <= 1'b0;
        wait_drained();
        write_line_count(lines);
    endtask

    // Receiver side. It either serves a long hold requested by the stimulus or
    // drops ready at random with the current idle chance.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: far beyond the slowest passing run, where every divide takes
    // its full loop and both sides stall as long as the idle chances allow.
    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        // Every input has a known value from time zero.
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ------------------------------------------------------------------
        // Directed part. The sender idles a little, the receiver a lot.
        // ------------------------------------------------------------------
        send_idle_pct = 10;
        recv_idle_pct = 85;

        // line_count is still zero from reset, so every step reports done.
        // All registers are zero: a divide here hits a zero divisor.
        send_instr(encode_instr(KIND_DIV, OPND_IMM, GPR_AX, 32'd5, GPR_AX,
                                OPND_IMM, GPR_AX, '0, '0, '0));
        send_instr(encode_instr(KIND_JMP, OPND_IMM, GPR_AX, '0, GPR_AX,
                                OPND_IMM, GPR_AX, '0, 7'd127, '0));
        send_instr(encode_instr(KIND_PRINT, OPND_IMM, GPR_AX, INT_MIN_W, GPR_AX,
                                OPND_IMM, GPR_AX, '0, '0, '0));

        // Largest meaningful program length.
        reconfigure(8'd128);

        // The most negative value divided by minus one wraps onto itself.
        send_instr(encode_instr(KIND_READ, OPND_IMM, GPR_AX, '0, GPR_AX,
                                OPND_IMM, GPR_AX, '0, '0, INT_MIN_W));
        send_instr(encode_instr(KIND_READ, OPND_IMM, GPR_AX, '0, GPR_BX,
                                OPND_IMM, GPR_AX, '0, '0, MINUS_ONE));
        send_instr(encode_instr(KIND_DIV, OPND_REG, GPR_AX, '0, GPR_BX,
                                OPND_IMM, GPR_AX, '0, '0, '0));
        send_instr(encode_instr(KIND_PRINT, OPND_REG, GPR_BX, '0, GPR_AX,
                                OPND_IMM, GPR_AX, '0, '0, '0));
        // Add, sub and mul wrap at 32 bits.
        send_instr(encode_instr(KIND_READ, OPND_IMM, GPR_AX, '0, GPR_CX,
                                OPND_IMM, GPR_AX, '0, '0, INT_MAX_W));
        send_instr(encode_instr(KIND_ADD, OPND_IMM, GPR_AX, 32'd1, GPR_CX,
                                OPND_IMM, GPR_AX, '0, '0, '0));
        send_instr(encode_instr(KIND_SUB, OPND_IMM, GPR_AX, INT_MIN_W, GPR_DX,
                                OPND_IMM, GPR_AX, '0, '0, '0));
        send_instr(encode_instr(KIND_MUL, OPND_IMM, GPR_AX, INT_MAX_W, GPR_CX,
                                OPND_IMM, GPR_AX, '0, '0, '0));
        // Source over destination with mixed signs truncates toward zero.
        send_instr(encode_instr(KIND_MOV, OPND_IMM, GPR_AX, -32'sd7, GPR_DX,
                                OPND_IMM, GPR_AX, '0, '0, '0));
        send_instr(encode_instr(KIND_READ, OPND_IMM, GPR_AX, '0, GPR_AX,
                                OPND_IMM, GPR_AX, '0, '0, 32'd20));
        send_instr(encode_instr(KIND_DIV, OPND_REG, GPR_AX, '0, GPR_DX,
                                OPND_IMM, GPR_AX, '0, '0, '0));
        send_instr(encode_instr(KIND_PRINT, OPND_REG, GPR_DX, '0, GPR_AX,
                                OPND_IMM, GPR_AX, '0, '0, '0));
        // One of each compare, with register and immediate operands.
        send_instr(encode_instr(KIND_JE, OPND_REG, GPR_AX, '0, GPR_AX,
                                OPND_IMM, GPR_AX, 32'd20, 7'd0, '0));
        send_instr(encode_instr(KIND_JNE, OPND_REG, GPR_AX, '0, GPR_AX,
                                OPND_REG, GPR_AX, '0, 7'd90, '0));
        send_instr(encode_instr(KIND_JG, OPND_IMM, GPR_AX, INT_MAX_W, GPR_AX,
                                OPND_IMM, GPR_AX, INT_MIN_W, 7'd45, '0));
        send_instr(encode_instr(KIND_JGE, OPND_REG, GPR_BX, '0, GPR_AX,
                                OPND_IMM, GPR_AX, INT_MIN_W, 7'd85, '0));
        send_instr(encode_instr(KIND_JL, OPND_IMM, GPR_AX, MINUS_ONE, GPR_AX,
                                OPND_IMM, GPR_AX, '0, 7'd126, '0));
        send_instr(encode_instr(KIND_JLE, OPND_IMM, GPR_AX, 32'd1, GPR_AX,
                                OPND_IMM, GPR_AX, '0, 7'd3, '0));
        // The spare kinds only advance the line.
        send_instr(encode_instr(KIND_SPARE_LO, OPND_REG, GPR_CX, MINUS_ONE, GPR_DX,
                                OPND_REG, GPR_BX, MINUS_ONE, 7'd127, MINUS_ONE));
        send_instr(encode_instr(KIND_SPARE_HI, OPND_REG, GPR_DX, MINUS_ONE, GPR_CX,
                                OPND_REG, GPR_DX, MINUS_ONE, 7'd127, MINUS_ONE));
        // Jump to the last line, then step off the end of the program.
        send_instr(encode_instr(KIND_JMP, OPND_IMM, GPR_AX, '0, GPR_AX,
                                OPND_IMM, GPR_AX, '0, 7'd127, '0));
        send_instr(encode_instr(KIND_MOV, OPND_REG, GPR_CX, '0, GPR_BX,
                                OPND_IMM, GPR_AX, '0, '0, '0));

        // ------------------------------------------------------------------
        // First random phase: sender mostly busy, receiver mostly stalling.
        // It opens with a long straight run so the line counter wraps.
        // ------------------------------------------------------------------
        reconfigure(LINE_W'($urandom_range(1, 127)));
        send_idle_pct = 10;
        recv_idle_pct = 85;
        run_random(300, 1'b1);
        run_random(200, 1'b0);

        // ------------------------------------------------------------------
        // Second random phase: the roles swap. line_count above the program
        // size is clamped. Halfway through the sender stops until every
        // result is back, so the block runs completely empty once.
        // ------------------------------------------------------------------
        reconfigure(8'd255);
        send_idle_pct = 85;
        recv_idle_pct = 10;
        run_random(250, 1'b0);
        in_valid <= 1'b0;
        wait_drained();
        run_random(250, 1'b0);

        // ------------------------------------------------------------------
        // Third random phase: no idling on either side, except one long
        // receiver hold while the sender keeps offering beats, which fills
        // the decode queue and backs up the input.
        // ------------------------------------------------------------------
        reconfigure(8'd1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(60, 1'b0);
        hold_left = 400;
        run_random(440, 1'b0);

        // Let everything come out, then give the back end time to show any
        // stray beat before the verdict.
        in_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && results_owed == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
